>>> sv/u8dec_pkg.sv
`timescale 1ns / 1ps

package u8dec_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CodeWidth  = 32;
   localparam int unsigned CountWidth = 3;

   // Fixed offsets removed at the end of a sequence, by trailing-byte count
   localparam logic [CodeWidth-1:0] Offset1 = 32'h0000_3080;
   localparam logic [CodeWidth-1:0] Offset2 = 32'h000E_2080;
   localparam logic [CodeWidth-1:0] Offset3 = 32'h03C8_2080;
   localparam logic [CodeWidth-1:0] Offset4 = 32'hFA08_2080;
   localparam logic [CodeWidth-1:0] Offset5 = 32'h8208_2080;

   typedef struct packed {
      logic [CodeWidth-1:0]  accumulator;
      logic [CountWidth-1:0] bytes_remaining;
      logic [CountWidth-1:0] sequence_length;
   } u8dec_state_type;

   typedef struct packed {
      logic [CodeWidth-1:0] code_point;
      logic                 truncated;
      logic                 final_char;
   } u8dec_result_type;

   // Trailing-byte count announced by a lead byte
   function automatic logic [CountWidth-1:0] lead_trailing(input logic [ByteWidth-1:0] b);
      logic [CountWidth-1:0] t;
      t = '0;
      case (b) inside
         [8'h00:8'hBF]: t = 3'd0;
         [8'hC0:8'hDF]: t = 3'd1;
         [8'hE0:8'hEF]: t = 3'd2;
         [8'hF0:8'hF7]: t = 3'd3;
         [8'hF8:8'hFB]: t = 3'd4;
         default:       t = 3'd5;
      endcase
      return t;
   endfunction

   function automatic logic [CodeWidth-1:0] len_offset(input logic [CountWidth-1:0] n);
      logic [CodeWidth-1:0] o;
      o = '0;
      case (n)
         3'd1:    o = Offset1;
         3'd2:    o = Offset2;
         3'd3:    o = Offset3;
         3'd4:    o = Offset4;
         3'd5:    o = Offset5;
         3'd7:    o = Offset1;
         default: o = '0;
      endcase
      return o;
   endfunction

endpackage

>>> sv/u8dec_step.sv
`timescale 1ns / 1ps

module u8dec_step (
   input  u8dec_pkg::u8dec_state_type  cur_state,
   input  logic [7:0]                  byte_in,
   input  logic                        last_byte,
   output u8dec_pkg::u8dec_state_type  nxt_state,
   output logic                        has_result,
   output u8dec_pkg::u8dec_result_type result
);
   import u8dec_pkg::*;

   logic [CountWidth-1:0] trail;
   logic [CodeWidth-1:0]  sum;

   assign trail = lead_trailing(byte_in);
   assign sum   = cur_state.accumulator + {{(CodeWidth-ByteWidth){1'b0}}, byte_in};

   always_comb begin
      nxt_state         = '0;
      has_result        = 1'b0;
      result.code_point = '0;
      result.truncated  = 1'b0;
      result.final_char = last_byte;
      if (cur_state.bytes_remaining == '0) begin
         if (trail == '0) begin
            has_result        = 1'b1;
            result.code_point = {{(CodeWidth-ByteWidth){1'b0}}, byte_in};
         end else if (last_byte) begin
            has_result       = 1'b1;
            result.truncated = 1'b1;
         end else begin
            // open a sequence
            nxt_state.accumulator     = {{(CodeWidth-ByteWidth-6){1'b0}}, byte_in, 6'b0};
            nxt_state.bytes_remaining = trail;
            nxt_state.sequence_length = trail;
         end
      end else if (cur_state.bytes_remaining == 3'd1) begin
         has_result        = 1'b1;
         result.code_point = sum - len_offset(cur_state.sequence_length);
      end else if (last_byte) begin
         has_result       = 1'b1;
         result.truncated = 1'b1;
      end else begin
         nxt_state.accumulator     = {sum[CodeWidth-7:0], 6'b0};
         nxt_state.bytes_remaining = cur_state.bytes_remaining - 3'd1;
         nxt_state.sequence_length = cur_state.sequence_length;
      end
   end

endmodule

>>> sv/u8dec_out_buf.sv
`timescale 1ns / 1ps

module u8dec_out_buf (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  u8dec_pkg::u8dec_result_type push_data,
   output logic                        space,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output u8dec_pkg::u8dec_result_type rsp_data
);
   import u8dec_pkg::*;

   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   u8dec_result_type main_ff, main_in;
   u8dec_result_type skid_ff, skid_in;
   logic             pop;

   assign pop       = main_valid_ff & rsp_ready;
   assign space     = ~skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            // advance the parked word
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_in       = push_data;
         end else begin
            main_valid_in = 1'b1;
            main_in       = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

>>> sv/utf8_to_utf32_decoder.sv
`timescale 1ns / 1ps
// A result word is registered in the output buffer before it is valid on rsp_.
// Throughput: one input word per cycle while req_ready is high; the sequence update is one add, subtract and shift.
// A two-entry output buffer keeps req_ready high while one result waits on rsp_ready.
// Reset clears the sequence state to idle and empties the output buffer.
module utf8_to_utf32_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_code_point,
   output logic        rsp_truncated,
   output logic        rsp_final_char
);
   import u8dec_pkg::*;

   u8dec_state_type  state_ff, state_in;
   u8dec_state_type  step_state;
   u8dec_result_type step_result;
   u8dec_result_type out_data;
   logic             step_has_result;
   logic             accept;
   logic             space;

   assign req_ready = space;
   assign accept    = req_valid & space;

   u8dec_step u_step (
      .cur_state  (state_ff),
      .byte_in    (req_byte_in),
      .last_byte  (req_last_byte),
      .nxt_state  (step_state),
      .has_result (step_has_result),
      .result     (step_result)
   );

   // hold state unless a word is taken
   assign state_in = accept ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   u8dec_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept & step_has_result),
      .push_data (step_result),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (out_data)
   );

   assign rsp_code_point = out_data.code_point;
   assign rsp_truncated  = out_data.truncated;
   assign rsp_final_char = out_data.final_char;

endmodule

>>> tb/utf8_to_utf32_decoder_tb.sv
`timescale 1ns / 1ps

module utf8_to_utf32_decoder_tb;
   import u8dec_pkg::*;

   localparam int unsigned CycleLimit = 400000;

   typedef logic [7:0] byte_string_type[$];

   // Predicts the code point words of the decoder and holds them until they come out
   class code_point_tracker_type;
      logic [CodeWidth-1:0]  accum;
      logic [CountWidth-1:0] left;
      logic [CountWidth-1:0] seq_len;
      logic [CodeWidth-1:0]  offsets [6];
      u8dec_result_type      pending_points [$];
      int unsigned bytes_seen, points_seen, cut_seen, strings_seen, errors;

      function new();
         offsets = '{'0, Offset1, Offset2, Offset3, Offset4, Offset5};
         accum = '0;
         left = '0;
         seq_len = '0;
         bytes_seen = 0;
         points_seen = 0;
         cut_seen = 0;
         strings_seen = 0;
         errors = 0;
      endfunction

      function logic [CountWidth-1:0] trailing_count(input logic [7:0] b);
         if (b < 8'hC0) return 3'd0;
         if (b < 8'hE0) return 3'd1;
         if (b < 8'hF0) return 3'd2;
         if (b < 8'hF8) return 3'd3;
         if (b < 8'hFC) return 3'd4;
         return 3'd5;
      endfunction

      function void take_byte(input logic [7:0] b, input logic last);
         u8dec_result_type w;
         bit emit;
         logic [CountWidth-1:0] t;
         emit = 1'b0;
         w = '0;
         bytes_seen++;
         if (left == 0) begin
            t = trailing_count(b);
            if (t == 0) begin
               w.code_point = {24'd0, b};
               w.final_char = last;
               emit = 1'b1;
            end else if (last) begin
               w.truncated = 1'b1;
               w.final_char = 1'b1;
               emit = 1'b1;
            end else begin
               accum = {24'd0, b} << 6;
               left = t;
               seq_len = t;
            end
         end else begin
            accum = accum + {24'd0, b};
            if (left == 1) begin
               w.code_point = accum - offsets[seq_len];
               w.final_char = last;
               emit = 1'b1;
            end else if (last) begin
               w.truncated = 1'b1;
               w.final_char = 1'b1;
               emit = 1'b1;
            end else begin
               accum = accum << 6;
               left = left - 1'b1;
            end
         end
         if (emit) begin
            pending_points.insert(pending_points.size(), w);
            accum = '0;
            left = '0;
            seq_len = '0;
         end
      endfunction

      function void check_code_point(input logic [CodeWidth-1:0] cp, input logic tr,
                                     input logic fc);
         u8dec_result_type w;
         if (pending_points.size() == 0) begin
            $display("%0t: unexpected word: code_point %h truncated %b final_char %b",
                     $time, cp, tr, fc);
            errors++;
            return;
         end
         w = pending_points.pop_front();
         points_seen++;
         if (w.truncated) cut_seen++;
         if (w.final_char) strings_seen++;
         if (cp !== w.code_point) begin
            $display("%0t: code_point expected %h actual %h", $time, w.code_point, cp);
            errors++;
         end
         if (tr !== w.truncated) begin
            $display("%0t: truncated expected %b actual %b", $time, w.truncated, tr);
            errors++;
         end
         if (fc !== w.final_char) begin
            $display("%0t: final_char expected %b actual %b", $time, w.final_char, fc);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_byte_in = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_code_point;
   logic        rsp_truncated;
   logic        rsp_final_char;

   bit sender_idles = 1'b1;
   bit receiver_idles = 1'b1;
   int unsigned cycle_count = 0;

   code_point_tracker_type board = new();

   utf8_to_utf32_decoder uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_in    (req_byte_in),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_truncated  (rsp_truncated),
      .rsp_final_char (rsp_final_char)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.take_byte(req_byte_in, req_last_byte);
      if (!reset && rsp_valid && rsp_ready)
         board.check_code_point(rsp_code_point, rsp_truncated, rsp_final_char);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout with %0d words outstanding", $time,
                  board.pending_points.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side: stall in random bursts while allowed, otherwise always ready
   always begin
      @(negedge clock);
      if (!receiver_idles) begin
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(0, 16)) @(negedge clock);
      end else begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(negedge clock);
      end
   end

   // Called at a falling edge; returns at a falling edge
   task automatic push_byte(input logic [7:0] b, input logic last);
      req_byte_in <= b;
      req_last_byte <= last;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (sender_idles && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
   endtask

   task automatic push_string(input byte_string_type s);
      foreach (s[i]) push_byte(s[i], i == s.size() - 1);
   endtask

   // Hold the sender until every predicted word has come out
   task automatic drain_points();
      req_valid <= 1'b0;
      do @(negedge clock); while (board.pending_points.size() != 0);
   endtask

   function automatic logic [7:0] pick_lead(input int unsigned t);
      case (t)
         0:       return 8'($urandom_range(8'h00, 8'hBF));
         1:       return 8'($urandom_range(8'hC0, 8'hDF));
         2:       return 8'($urandom_range(8'hE0, 8'hEF));
         3:       return 8'($urandom_range(8'hF0, 8'hF7));
         4:       return 8'($urandom_range(8'hF8, 8'hFB));
         default: return 8'($urandom_range(8'hFC, 8'hFF));
      endcase
   endfunction

   function automatic logic [7:0] pick_trail();
      if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(8'h80, 8'hBF));
   endfunction

   // Mostly well-formed characters, some cut short, some raw noise bytes
   task automatic random_strings(input int unsigned count);
      int unsigned sent;
      int unsigned t;
      int unsigned cut;
      bit closes;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            sent++;
         end else begin
            t = $urandom_range(0, 5);
            closes = ($urandom_range(0, 7) == 0);
            cut = t + 1;
            if (t != 0 && $urandom_range(0, 11) == 0) cut = $urandom_range(0, t - 1);
            for (int unsigned k = 0; k <= t && k <= cut; k++) begin
               push_byte(k == 0 ? pick_lead(t) : pick_trail(), k == cut || (k == t && closes));
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_string('{8'h00, 8'h7F});
      push_string('{8'h80, 8'hC0, 8'h80});
      push_string('{8'hEF, 8'hBF, 8'hBF});
      push_string('{8'hF0, 8'h90, 8'h80, 8'h80});
      // six-byte sequence of all ones wraps past 2^32
      push_string('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
      push_string('{8'hF8, 8'h88, 8'h80});
      push_string('{8'hC3});
      // lead bytes inside a sequence count as trailing bytes
      push_string('{8'hE0, 8'hFF, 8'hC0});
      drain_points();

      random_strings(600);
      drain_points();
      receiver_idles = 1'b0;
      random_strings(450);
      receiver_idles = 1'b1;
      random_strings(250);
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      random_strings(225);
      drain_points();
      repeat (4) @(negedge clock);

      $display("Fed %0d bytes; checked %0d code points, %0d of them closing a string",
               board.bytes_seen, board.points_seen, board.strings_seen);
      $display("and %0d cut short, with random stalls on both channels",
               board.cut_seen);
      if (board.errors == 0 && board.pending_points.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/u8dec_pkg.sv
sv/u8dec_step.sv
sv/u8dec_out_buf.sv
sv/utf8_to_utf32_decoder.sv
tb/utf8_to_utf32_decoder_tb.sv
